@@ src/efr_pkg.sv @@
// ============================================================================
// efr_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// escaped frame receiver.
// ============================================================================
`default_nettype none

package efr_pkg;

    localparam int CfgIndexWidth = 2;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_START_CODE  = 2'd0,
        REG_END_CODE    = 2'd1,
        REG_ESCAPE_CODE = 2'd2,
        REG_UNUSED      = 2'd3
    } efr_reg_index_t;

    localparam logic [7:0]  StartCodeReset  = 8'hFD;
    localparam logic [7:0]  EndCodeReset    = 8'hFE;
    localparam logic [7:0]  EscapeCodeReset = 8'hFF;
    localparam logic [15:0] CrcInit         = 16'hFFFF;
    localparam logic [15:0] CrcPoly         = 16'h1021;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } efr_codes_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       discard;
        logic       frame_done;
        logic       crc_good;
        logic [6:0] frame_length;
    } efr_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/efr_core.sv @@
// ============================================================================
// efr_core
// Framing state and per-byte decision logic: delimiter and escape handling,
// byte counting, delayed CRC accumulation and the end-of-frame check.
// ============================================================================
`default_nettype none

module efr_core
    import efr_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire efr_codes_t  codes,
    output efr_result_t      result
);

    localparam int CountWidth = $clog2(BUFFER_BYTES + 1);
    localparam logic [CountWidth-1:0] CountFull = CountWidth'(BUFFER_BYTES);
    localparam logic [CountWidth-1:0] CountTwo  = CountWidth'(2);

    logic                  in_frame_reg, in_frame_next;
    logic                  escape_reg, escape_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            tail0_reg, tail0_next;
    logic [7:0]            tail1_reg, tail1_next;

    logic                  full;
    logic [CountWidth-1:0] count_base;
    logic [15:0]           crc_base;
    logic [7:0]            tail0_base;
    logic [7:0]            tail1_base;
    logic                  is_code;
    logic                  do_append;

    assign full       = (count_reg >= CountFull);
    assign count_base = full ? '0 : count_reg;
    assign crc_base   = full ? CrcInit : crc_reg;
    assign tail0_base = full ? 8'h00 : tail0_reg;
    assign tail1_base = full ? 8'h00 : tail1_reg;
    assign is_code    = (rx_byte == codes.start_code) || (rx_byte == codes.end_code)
                     || (rx_byte == codes.escape_code);

    always_comb begin
        in_frame_next = in_frame_reg;
        escape_next   = escape_reg;
        count_next    = count_base;
        crc_next      = crc_base;
        tail0_next    = tail0_base;
        tail1_next    = tail1_base;
        do_append     = 1'b0;
        result        = '0;
        result.discard = full;

        if (escape_reg) begin
            do_append   = is_code;
            escape_next = 1'b0;
        end else if (rx_byte == codes.start_code) begin
            if (count_base != '0) begin
                result.discard = 1'b1;
            end
            count_next    = '0;
            crc_next      = CrcInit;
            tail0_next    = 8'h00;
            tail1_next    = 8'h00;
            in_frame_next = 1'b1;
        end else if ((rx_byte == codes.end_code) && in_frame_reg) begin
            result.frame_done   = 1'b1;
            result.frame_length = 7'(count_base);
            result.crc_good     = (count_base >= CountTwo) && ({tail0_base, tail1_base} == crc_base);
            in_frame_next = 1'b0;
            count_next    = '0;
            crc_next      = CrcInit;
            tail0_next    = 8'h00;
            tail1_next    = 8'h00;
        end else if ((rx_byte == codes.escape_code) && in_frame_reg) begin
            escape_next = 1'b1;
        end else if (in_frame_reg) begin
            do_append = 1'b1;
        end

        if (do_append) begin
            if (count_base >= CountTwo) begin
                crc_next = crc_byte(crc_base, tail0_base);
            end
            tail0_next        = tail1_base;
            tail1_next        = rx_byte;
            count_next        = count_base + 1'b1;
            result.data_byte  = rx_byte;
            result.data_valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            escape_reg   <= 1'b0;
            count_reg    <= '0;
            crc_reg      <= CrcInit;
            tail0_reg    <= 8'h00;
            tail1_reg    <= 8'h00;
        end else if (step) begin
            in_frame_reg <= in_frame_next;
            escape_reg   <= escape_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            tail0_reg    <= tail0_next;
            tail1_reg    <= tail1_next;
        end
    end

endmodule

`default_nettype wire

@@ src/escaped_frame_receiver_crc16_top.sv @@
// ============================================================================
// escaped_frame_receiver_crc16_top
// Byte-stuffed frame receiver with trailing CRC-16/CCITT-FALSE check.
// ============================================================================
// One received byte per transaction in, one result transaction out for every
// byte. A byte passes an input register and the framing logic, and its result
// lands in an output register. A new byte is taken every cycle while the output
// side keeps up; the framing logic updates its state and takes its bytewise CRC
// step for a whole byte at once, which sets that rate. Kept payload bytes
// appear with data_valid set; at an end code tlast marks the frame end together
// with its length (payload plus two CRC bytes) and the CRC verdict. Delimiter
// codes are written through the cfg port at indexes 0 (start), 1 (end) and 2
// (escape) by the user while the block is idle; the block does not enforce it.
`default_nettype none

module escaped_frame_receiver_crc16_top
    import efr_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,   // rx_byte[7:0]
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // data_byte[7:0], frame_length[14:8]
    output logic [2:0]                    m_axis_tuser,   // data_valid[0], discard[1], crc_good[2]
    output logic                          m_axis_tlast,   // frame_done
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [7:0]               cfg_data
);

    efr_codes_t  codes_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    efr_result_t out_result_reg;
    efr_result_t core_result;
    logic        out_free;
    logic        step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = aresetn && (!in_valid_reg || out_free);
    assign cfg_ready     = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.start_code  <= StartCodeReset;
            codes_reg.end_code    <= EndCodeReset;
            codes_reg.escape_code <= EscapeCodeReset;
        end else if (cfg_valid && cfg_ready) begin
            case (efr_reg_index_t'(cfg_index))
                REG_START_CODE:  codes_reg.start_code  <= cfg_data;
                REG_END_CODE:    codes_reg.end_code    <= cfg_data;
                REG_ESCAPE_CODE: codes_reg.escape_code <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    efr_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .codes   (codes_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg.frame_length, out_result_reg.data_byte};
    assign m_axis_tuser  = {out_result_reg.crc_good, out_result_reg.discard,
                            out_result_reg.data_valid};
    assign m_axis_tlast  = out_result_reg.frame_done;

    // A passing CRC check only comes with a completed frame of at least two bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tlast && (m_axis_tdata[14:9] != 6'd0)))
        else $error("crc_good reported without a completed frame of two or more bytes");

    // The end code itself is never appended to the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[0])
        else $error("frame end reported together with an appended byte");

    // A byte held in the input register moves on whenever the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending byte did not advance into an empty output register");

    // An empty input register always accepts a new transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while the input register is empty");

endmodule

`default_nettype wire
